>>> design/pte_pkg.sv
// shared types, sizes and operation codes for the positional table engine
package pte_pkg;

  // table geometry
  localparam int TABLE_SIZE = 8;
  localparam int IDX_W = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1;
  localparam int OP_W = 3;
  localparam int POS_W = 4;
  localparam int VAL_W = 32;
  localparam int FIDX_W = 3;

  // command queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // operation codes of the request channel
  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_UPDATE  = 3'd2,
    OP_REVERSE = 3'd3,
    OP_SEARCH  = 3'd4,
    OP_READ    = 3'd5
  } op_code_t;

  // classified command kinds handed to the back end
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_UPDATE  = 3'd3,
    CMD_REVERSE = 3'd4,
    CMD_SEARCH  = 3'd5,
    CMD_READ    = 3'd6,
    CMD_BAD_POS = 3'd7
  } cmd_kind_t;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } req_item_t;

  typedef struct packed {
    logic                    status;
    logic                    found;
    logic [FIDX_W-1:0]       found_index;
    logic signed [VAL_W-1:0] read_value;
  } rsp_item_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  slot;
    logic [VAL_W-1:0]  value;
  } cmd_t;

endpackage

>>> design/pte_front.sv
// front end: takes request transactions and classifies them into commands
module pte_front (
  input  logic              req_valid,
  output logic              req_stall,
  input  pte_pkg::req_item_t req,
  input  logic              queue_full,
  output logic              push,
  output pte_pkg::cmd_t     cmd
);
  import pte_pkg::*;

  logic pos_ok;
  logic [POS_W-1:0] slot_wide;

  // position check against the 1-based table range
  assign pos_ok    = (req.position != '0) && (req.position <= POS_W'(TABLE_SIZE));
  assign slot_wide = req.position - POS_W'(1);

  // classify the operation
  always_comb begin
    cmd.slot  = IDX_W'(slot_wide);
    cmd.value = req.item_value;
    unique case (req.operation)
      OP_INSERT:  cmd.kind = pos_ok ? CMD_INSERT : CMD_BAD_POS;
      OP_DELETE:  cmd.kind = pos_ok ? CMD_DELETE : CMD_BAD_POS;
      OP_UPDATE:  cmd.kind = pos_ok ? CMD_UPDATE : CMD_BAD_POS;
      OP_READ:    cmd.kind = pos_ok ? CMD_READ : CMD_BAD_POS;
      OP_REVERSE: cmd.kind = CMD_REVERSE;
      OP_SEARCH:  cmd.kind = CMD_SEARCH;
      default:    cmd.kind = CMD_NONE;
    endcase
  end

  // a transaction goes straight into the queue when there is room
  assign req_stall = queue_full;
  assign push      = req_valid && !queue_full;

endmodule

>>> design/pte_queue.sv
// short command queue decoupling front end and back end
module pte_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pte_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          nonempty,
  input  logic          pop,
  output pte_pkg::cmd_t head
);
  import pte_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

>>> design/pte_back.sv
// back end: shift-linked table registers, command execution and response register
module pte_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  pte_pkg::cmd_t      cmd,
  output logic               pop,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output pte_pkg::rsp_item_t rsp
);
  import pte_pkg::*;

  logic [VAL_W-1:0]  entries      [TABLE_SIZE];
  logic [VAL_W-1:0]  entries_next [TABLE_SIZE];
  logic              hit;
  logic [FIDX_W-1:0] hit_idx;
  rsp_item_t         rsp_next;

  // take a command whenever the response register is free or draining
  assign pop = cmd_valid && (!rsp_valid || !rsp_stall);

  // parallel compare with lowest index winning
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if (entries[i] == cmd.value) begin
        hit     = 1'b1;
        hit_idx = FIDX_W'(i);
      end
    end
  end

  // per-entry next value from its neighbors
  always_comb begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      entries_next[i] = entries[i];
      unique case (cmd.kind)
        CMD_INSERT: begin
          if (IDX_W'(i) == cmd.slot) begin
            entries_next[i] = cmd.value;
          end else if (i > 0 && IDX_W'(i) > cmd.slot) begin
            entries_next[i] = entries[(i > 0) ? i - 1 : 0];
          end
        end
        CMD_DELETE: begin
          if (i == TABLE_SIZE - 1) begin
            entries_next[i] = '0;
          end else if (IDX_W'(i) >= cmd.slot) begin
            entries_next[i] = entries[(i < TABLE_SIZE - 1) ? i + 1 : i];
          end
        end
        CMD_UPDATE: begin
          if (IDX_W'(i) == cmd.slot) begin
            entries_next[i] = cmd.value;
          end
        end
        CMD_REVERSE: entries_next[i] = entries[TABLE_SIZE - 1 - i];
        default:     entries_next[i] = entries[i];
      endcase
    end
  end

  // response fields
  always_comb begin
    rsp_next = '0;
    unique case (cmd.kind)
      CMD_BAD_POS: rsp_next.status = 1'b1;
      CMD_SEARCH: begin
        rsp_next.found       = hit;
        rsp_next.found_index = hit_idx;
      end
      CMD_READ:    rsp_next.read_value = entries[cmd.slot];
      default:     rsp_next = '0;
    endcase
  end

  // table registers, entry i resets to i
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        entries[i] <= VAL_W'(i);
      end
    end else if (pop) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        entries[i] <= entries_next[i];
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pop) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> design/positional_table_engine.sv
// top level of the positional table engine
//
// A table of TABLE_SIZE signed 32-bit words held in registers linked to
// their neighbors. Each request transaction carries one operation (insert,
// delete, update, reverse, search, read) and yields exactly one response
// transaction, in request order.
// Request channel: req_valid / req_stall / req. The front end checks the
// position and places a classified command into a two-entry queue; req_stall
// rises only when that queue is full.
// Response channel: rsp_valid / rsp_stall / rsp. The back end executes one
// command per cycle on the table and loads the response register, as long
// as rsp_stall does not hold that register. An accepted request is
// registered in the queue, then its response in the response register.
// Throughput: one transaction per cycle while rsp_stall is low; every shift,
// mirror and parallel compare is combinational ahead of the table registers.
// When rsp_stall is held, the response register holds its transaction, the
// queue fills, and then req_stall rises until the receiver drains it.
// Reset (rst, synchronous) empties the queue and response register and loads
// entry i with the value i.
module positional_table_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  pte_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output pte_pkg::rsp_item_t rsp
);
  import pte_pkg::*;

  logic queue_full;
  logic queue_nonempty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head_cmd;

  // classify incoming transactions
  pte_front u_front (
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  // command queue
  pte_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .nonempty (queue_nonempty),
    .pop      (pop),
    .head     (head_cmd)
  );

  // table and execution
  pte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (queue_nonempty),
    .cmd       (head_cmd),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
